// ----- rtl/ppu_pkg.sv -----
`default_nettype none
package ppu_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int NUM_SUBS  = 8;
  localparam int NUM_ENT   = NUM_SLOTS * NUM_SUBS;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SUB_W     = (NUM_SUBS > 1) ? $clog2(NUM_SUBS) : 1;
  localparam int ENT_W     = (NUM_ENT > 1) ? $clog2(NUM_ENT) : 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [8:0] DRIFT_LIMIT = 9'sd25;

  localparam logic [15:0] RST_LIFETIME  = 16'd60;
  localparam logic [14:0] RST_SPEED     = 15'd8;
  localparam logic [14:0] RST_MIN_SPEED = 15'd8;
  localparam logic [15:0] RST_GRAVITY   = 16'd1;
  localparam logic [31:0] RST_SEED      = 32'd1;

  typedef enum logic [2:0] {
    CFG_LIFETIME  = 3'd0,
    CFG_SPEED     = 3'd1,
    CFG_MIN_SPEED = 3'd2,
    CFG_GRAVITY   = 3'd3,
    CFG_SEED      = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_SPAWN = 2'd0,
    OP_DRIFT = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [7:0]  sx;
    logic signed [7:0]  sy;
  } cmd_t;

  typedef struct packed {
    logic [15:0]        lifetime;
    logic [14:0]        speed;
    logic [14:0]        min_speed;
    logic signed [15:0] gravity;
    logic [31:0]        seed;
  } cfg_t;

  typedef struct packed {
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] vx;
    logic [15:0] vy;
  } kin_t;

  typedef struct packed {
    logic signed [8:0] dx;
    logic signed [8:0] dy;
  } drift_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_SP_DRAW1,
    ST_SP_WAIT1,
    ST_SP_DRAW2,
    ST_SP_WAIT2,
    ST_DR_RD,
    ST_DR_WR,
    ST_TK_RD,
    ST_TK_WR,
    ST_ACK
  } back_state_t;

endpackage
`default_nettype wire

// ----- rtl/particle_pool_update.sv -----
// Drift walks every sub-particle of every slot and tick every live sub-particle, each
// with a read and then a write over the particle stores; tick also waits for a free output.
// Spawn draws the two velocities of each sub-particle with the bit-serial remainder unit,
// which is shared by both draws of every sub-particle.
// The back end runs one command at a time; a two-entry queue decouples input from execution.
// Reset (synchronous, active low) is followed by a clearing pass over all 64 store entries.
`default_nettype none
module particle_pool_update (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Input channel: a transfer happens when in_valid and in_ready are both high.
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_opcode,
  input  wire logic signed [15:0] in_spawn_x,
  input  wire logic signed [15:0] in_spawn_y,
  input  wire logic signed [7:0]  in_shift_x,
  input  wire logic signed [7:0]  in_shift_y,
  // Result channel.
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_slot,
  output logic [2:0]              out_sub_index,
  output logic signed [15:0]      out_x,
  output logic signed [15:0]      out_y,
  output logic                    out_live,
  output logic                    out_last,
  // Configuration write port.
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  // Configuration registers. A write to the seed register also reloads the
  // generator state inside the back end in the cycle after, once the seed
  // register already holds the new value.
  ppu_pkg::cfg_t cfg_r;
  logic          seed_wr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lifetime  <= ppu_pkg::RST_LIFETIME;
      cfg_r.speed     <= ppu_pkg::RST_SPEED;
      cfg_r.min_speed <= ppu_pkg::RST_MIN_SPEED;
      cfg_r.gravity   <= ppu_pkg::RST_GRAVITY;
      cfg_r.seed      <= ppu_pkg::RST_SEED;
    end else if (cfg_we) begin
      case (cfg_index)
        ppu_pkg::CFG_LIFETIME:  cfg_r.lifetime  <= cfg_data[15:0];
        ppu_pkg::CFG_SPEED:     cfg_r.speed     <= cfg_data[14:0];
        ppu_pkg::CFG_MIN_SPEED: cfg_r.min_speed <= cfg_data[14:0];
        ppu_pkg::CFG_GRAVITY:   cfg_r.gravity   <= cfg_data[15:0];
        ppu_pkg::CFG_SEED:      cfg_r.seed      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_wr_r <= 1'b0;
    end else begin
      seed_wr_r <= cfg_we && (cfg_index == ppu_pkg::CFG_SEED);
    end
  end

  // The front end accepts and decodes commands; the back end runs them.
  logic          q_valid, q_ready, clr_busy;
  ppu_pkg::cmd_t q_cmd;

  ppu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_opcode  (in_opcode),
    .in_spawn_x (in_spawn_x),
    .in_spawn_y (in_spawn_y),
    .in_shift_x (in_shift_x),
    .in_shift_y (in_shift_y),
    .clr_busy   (clr_busy),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_cmd      (q_cmd)
  );

  // The back end owns the slot lives, the particle stores and the generator,
  // and emits every result through one output register.
  ppu_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .seed_wr       (seed_wr_r),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_cmd         (q_cmd),
    .clr_busy      (clr_busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_slot      (out_slot),
    .out_sub_index (out_sub_index),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_live      (out_live),
    .out_last      (out_last)
  );

endmodule
`default_nettype wire

// ----- rtl/ppu_ram.sv -----
`default_nettype none
module ppu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [$clog2(DEPTH)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]          wdata,
  input  wire logic [$clog2(DEPTH)-1:0]  raddr,
  output logic      [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/ppu_mod.sv -----
`default_nettype none
// Restoring remainder unit: one dividend bit per cycle.
module ppu_mod (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [14:0] divisor,
  output logic             done,
  output logic [14:0]      rem
);

  logic [31:0] dq_r, dq_nxt;
  logic [14:0] rem_r, rem_nxt;
  logic [14:0] div_r, div_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [15:0] trial;

  always_comb begin
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dq_r[31]};
    if (start) begin
      dq_nxt  = dividend;
      rem_nxt = '0;
      div_nxt = divisor;
      cnt_nxt = 6'd32;
    end else if (cnt_r != 6'd0) begin
      if (trial >= {1'b0, div_r}) begin
        trial = trial - {1'b0, div_r};
      end
      rem_nxt  = trial[14:0];
      dq_nxt   = {dq_r[30:0], 1'b0};
      cnt_nxt  = cnt_r - 6'd1;
      done_nxt = (cnt_r == 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done = done_r;
  assign rem  = (div_r == 15'd0) ? 15'd0 : rem_r;

endmodule
`default_nettype wire

// ----- rtl/ppu_front.sv -----
`default_nettype none
// Takes input transfers, decodes the opcode and holds commands in a short queue.
module ppu_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_opcode,
  input  wire logic signed [15:0] in_spawn_x,
  input  wire logic signed [15:0] in_spawn_y,
  input  wire logic signed [7:0]  in_shift_x,
  input  wire logic signed [7:0]  in_shift_y,
  input  wire logic               clr_busy,
  output logic                    q_valid,
  input  wire logic               q_ready,
  output ppu_pkg::cmd_t           q_cmd
);

  ppu_pkg::cmd_t q_r [ppu_pkg::QUEUE_DEPTH];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push, pop;
  ppu_pkg::cmd_t cmd_in;

  always_comb begin
    cmd_in.op = ppu_pkg::op_t'(in_opcode);
    cmd_in.x  = in_spawn_x;
    cmd_in.y  = in_spawn_y;
    cmd_in.sx = in_shift_x;
    cmd_in.sy = in_shift_y;
  end

  assign in_ready = !clr_busy && (cnt_r != 2'(ppu_pkg::QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ppu_back.sv -----
`default_nettype none
// Executes queued commands over the particle stores and drives the result register.
module ppu_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ppu_pkg::cfg_t      cfg,
  input  wire logic               seed_wr,
  input  wire logic               q_valid,
  output logic                    q_ready,
  input  wire ppu_pkg::cmd_t      q_cmd,
  output logic                    clr_busy,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_slot,
  output logic [2:0]              out_sub_index,
  output logic signed [15:0]      out_x,
  output logic signed [15:0]      out_y,
  output logic                    out_live,
  output logic                    out_last
);

  ppu_pkg::back_state_t state_r, state_nxt;
  logic [ppu_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [ppu_pkg::SUB_W-1:0]  sub_r, sub_nxt;
  ppu_pkg::cmd_t              cmd_r, cmd_nxt;
  logic [ppu_pkg::NUM_SLOTS-1:0] mask_r, mask_nxt;
  logic [15:0] life_r [ppu_pkg::NUM_SLOTS];
  logic [15:0] life_nxt [ppu_pkg::NUM_SLOTS];
  logic [31:0] rng_r, rng_nxt, rng_step;
  logic [15:0] vx_r, vx_nxt;

  logic        ov_r, ov_nxt;
  logic [2:0]  os_r, os_nxt, oi_r, oi_nxt;
  logic [15:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic        ol_r, ol_nxt, olast_r, olast_nxt;

  logic [ppu_pkg::ENT_W-1:0] ent_addr;
  logic           kin_we, dr_we;
  ppu_pkg::kin_t  kin_wd, kin_rd;
  ppu_pkg::drift_t dr_wd, dr_rd;

  logic        mod_start, mod_done;
  logic [14:0] mod_divisor, mod_rem;

  logic out_free, last_sub, last_slot, live_above, any_live;
  logic [ppu_pkg::SLOT_W-1:0] free_slot;
  logic [15:0] nx, ny;

  function automatic logic [31:0] xs32(input logic [31:0] v);
    logic [31:0] t;
    t = v ^ (v << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

  function automatic logic signed [8:0] nudge(input logic signed [8:0] d,
                                              input logic signed [7:0] s);
    logic signed [8:0] r;
    r = d;
    if ((s > 8'sd0 && d < ppu_pkg::DRIFT_LIMIT) ||
        (s < 8'sd0 && d > -ppu_pkg::DRIFT_LIMIT)) begin
      r = d + 9'(s);
    end
    return r;
  endfunction

  assign ent_addr  = ppu_pkg::ENT_W'(32'(slot_r) * ppu_pkg::NUM_SUBS + 32'(sub_r));
  assign out_free  = !ov_r || out_ready;
  assign last_sub  = (sub_r == ppu_pkg::SUB_W'(ppu_pkg::NUM_SUBS - 1));
  assign last_slot = (slot_r == ppu_pkg::SLOT_W'(ppu_pkg::NUM_SLOTS - 1));
  assign rng_step  = xs32(rng_r);
  assign q_ready   = (state_r == ppu_pkg::ST_IDLE);
  assign clr_busy  = (state_r == ppu_pkg::ST_CLR);

  always_comb begin
    free_slot = '0;
    any_live  = 1'b0;
    for (int j = ppu_pkg::NUM_SLOTS - 1; j >= 0; j--) begin
      if (life_r[j] == 16'd0) begin
        free_slot = ppu_pkg::SLOT_W'(j);
      end
      if (life_r[j] != 16'd0) begin
        any_live = 1'b1;
      end
    end
    live_above = 1'b0;
    for (int j = 0; j < ppu_pkg::NUM_SLOTS; j++) begin
      if (ppu_pkg::SLOT_W'(j) > slot_r && mask_r[j]) begin
        live_above = 1'b1;
      end
    end
  end

  always_comb begin
    nx = kin_rd.px + kin_rd.vx + 16'(dr_rd.dx);
    ny = kin_rd.py + kin_rd.vy + 16'(dr_rd.dy);
  end

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    sub_nxt   = sub_r;
    cmd_nxt   = cmd_r;
    mask_nxt  = mask_r;
    life_nxt  = life_r;
    rng_nxt   = rng_r;
    vx_nxt    = vx_r;
    ov_nxt    = ov_r && !out_ready;
    os_nxt    = os_r;
    oi_nxt    = oi_r;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    ol_nxt    = ol_r;
    olast_nxt = olast_r;
    kin_we    = 1'b0;
    kin_wd    = '0;
    dr_we     = 1'b0;
    dr_wd     = '0;
    mod_start = 1'b0;
    mod_divisor = cfg.min_speed;

    case (state_r)
      ppu_pkg::ST_CLR: begin
        kin_we = 1'b1;
        dr_we  = 1'b1;
        if (last_sub) begin
          sub_nxt = '0;
          if (last_slot) begin
            slot_nxt  = '0;
            state_nxt = ppu_pkg::ST_IDLE;
          end else begin
            slot_nxt = slot_r + 1'b1;
          end
        end else begin
          sub_nxt = sub_r + 1'b1;
        end
      end
      ppu_pkg::ST_IDLE: begin
        if (q_valid) begin
          cmd_nxt  = q_cmd;
          slot_nxt = '0;
          sub_nxt  = '0;
          case (q_cmd.op)
            ppu_pkg::OP_SPAWN: begin
              slot_nxt            = free_slot;
              life_nxt[free_slot] = cfg.lifetime;
              state_nxt           = ppu_pkg::ST_SP_DRAW1;
            end
            ppu_pkg::OP_DRIFT: begin
              state_nxt = ppu_pkg::ST_DR_RD;
            end
            ppu_pkg::OP_TICK: begin
              for (int j = 0; j < ppu_pkg::NUM_SLOTS; j++) begin
                mask_nxt[j] = (life_r[j] != 16'd0);
                if (life_r[j] != 16'd0) begin
                  life_nxt[j] = life_r[j] - 16'd1;
                end
              end
              state_nxt = any_live ? ppu_pkg::ST_TK_RD : ppu_pkg::ST_ACK;
            end
            default: begin
              state_nxt = ppu_pkg::ST_ACK;
            end
          endcase
        end
      end
      ppu_pkg::ST_SP_DRAW1: begin
        rng_nxt     = rng_step;
        mod_start   = 1'b1;
        mod_divisor = cfg.min_speed;
        state_nxt   = ppu_pkg::ST_SP_WAIT1;
      end
      ppu_pkg::ST_SP_WAIT1: begin
        if (mod_done) begin
          vx_nxt    = 16'(mod_rem) - 16'(cfg.min_speed >> 1);
          state_nxt = ppu_pkg::ST_SP_DRAW2;
        end
      end
      ppu_pkg::ST_SP_DRAW2: begin
        rng_nxt     = rng_step;
        mod_start   = 1'b1;
        mod_divisor = cfg.speed >> 1;
        state_nxt   = ppu_pkg::ST_SP_WAIT2;
      end
      ppu_pkg::ST_SP_WAIT2: begin
        if (mod_done) begin
          kin_we    = 1'b1;
          kin_wd.px = cmd_r.x;
          kin_wd.py = cmd_r.y;
          kin_wd.vx = vx_r;
          kin_wd.vy = 16'(mod_rem) - 16'(cfg.speed);
          if (last_sub) begin
            state_nxt = ppu_pkg::ST_ACK;
          end else begin
            sub_nxt   = sub_r + 1'b1;
            state_nxt = ppu_pkg::ST_SP_DRAW1;
          end
        end
      end
      ppu_pkg::ST_DR_RD: begin
        state_nxt = ppu_pkg::ST_DR_WR;
      end
      ppu_pkg::ST_DR_WR: begin
        dr_we    = 1'b1;
        dr_wd.dx = nudge(dr_rd.dx, cmd_r.sx);
        dr_wd.dy = nudge(dr_rd.dy, cmd_r.sy);
        state_nxt = ppu_pkg::ST_DR_RD;
        if (last_sub) begin
          sub_nxt = '0;
          if (last_slot) begin
            slot_nxt  = '0;
            state_nxt = ppu_pkg::ST_ACK;
          end else begin
            slot_nxt = slot_r + 1'b1;
          end
        end else begin
          sub_nxt = sub_r + 1'b1;
        end
      end
      ppu_pkg::ST_TK_RD: begin
        if (!mask_r[slot_r]) begin
          slot_nxt = slot_r + 1'b1;
          sub_nxt  = '0;
        end else if (out_free) begin
          state_nxt = ppu_pkg::ST_TK_WR;
        end
      end
      ppu_pkg::ST_TK_WR: begin
        kin_we    = 1'b1;
        kin_wd.px = nx;
        kin_wd.py = ny;
        kin_wd.vx = kin_rd.vx;
        kin_wd.vy = kin_rd.vy + cfg.gravity;
        ov_nxt    = 1'b1;
        os_nxt    = 3'(slot_r);
        oi_nxt    = 3'(sub_r);
        ox_nxt    = nx;
        oy_nxt    = ny;
        ol_nxt    = 1'b1;
        olast_nxt = last_sub && !live_above;
        state_nxt = ppu_pkg::ST_TK_RD;
        if (last_sub && !live_above) begin
          state_nxt = ppu_pkg::ST_IDLE;
        end else if (last_sub) begin
          sub_nxt  = '0;
          slot_nxt = slot_r + 1'b1;
        end else begin
          sub_nxt = sub_r + 1'b1;
        end
      end
      ppu_pkg::ST_ACK: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          os_nxt    = (cmd_r.op == ppu_pkg::OP_SPAWN) ? 3'(slot_r) : 3'd0;
          oi_nxt    = '0;
          ox_nxt    = '0;
          oy_nxt    = '0;
          ol_nxt    = 1'b0;
          olast_nxt = 1'b1;
          state_nxt = ppu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ppu_pkg::ST_IDLE;
      end
    endcase

    if (seed_wr) begin
      rng_nxt = cfg.seed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ppu_pkg::ST_CLR;
      slot_r  <= '0;
      sub_r   <= '0;
      mask_r  <= '0;
      rng_r   <= ppu_pkg::RST_SEED;
      ov_r    <= 1'b0;
      for (int j = 0; j < ppu_pkg::NUM_SLOTS; j++) begin
        life_r[j] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      sub_r   <= sub_nxt;
      mask_r  <= mask_nxt;
      rng_r   <= rng_nxt;
      ov_r    <= ov_nxt;
      life_r  <= life_nxt;
    end
    cmd_r   <= cmd_nxt;
    vx_r    <= vx_nxt;
    os_r    <= os_nxt;
    oi_r    <= oi_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    ol_r    <= ol_nxt;
    olast_r <= olast_nxt;
  end

  ppu_ram #(.WIDTH($bits(ppu_pkg::kin_t)), .DEPTH(ppu_pkg::NUM_ENT)) u_kin_ram (
    .clk   (clk),
    .we    (kin_we),
    .waddr (ent_addr),
    .wdata (kin_wd),
    .raddr (ent_addr),
    .rdata (kin_rd)
  );

  ppu_ram #(.WIDTH($bits(ppu_pkg::drift_t)), .DEPTH(ppu_pkg::NUM_ENT)) u_drift_ram (
    .clk   (clk),
    .we    (dr_we),
    .waddr (ent_addr),
    .wdata (dr_wd),
    .raddr (ent_addr),
    .rdata (dr_rd)
  );

  ppu_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (rng_step),
    .divisor  (mod_divisor),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign out_valid     = ov_r;
  assign out_slot      = os_r;
  assign out_sub_index = oi_r;
  assign out_x         = ox_r;
  assign out_y         = oy_r;
  assign out_live      = ol_r;
  assign out_last      = olast_r;

  a_tick_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ppu_pkg::ST_TK_WR |-> !ov_r)
    else $error("tick result loaded over a waiting result");

  a_kin_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    kin_we |-> (state_r == ppu_pkg::ST_CLR || state_r == ppu_pkg::ST_SP_WAIT2 ||
                state_r == ppu_pkg::ST_TK_WR))
    else $error("kinematic store written outside clear, spawn or tick");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == ppu_pkg::ST_SP_WAIT1 || state_r == ppu_pkg::ST_SP_WAIT2))
    else $error("remainder finished outside a spawn wait");

  a_tick_live_slot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ppu_pkg::ST_TK_WR |-> mask_r[slot_r])
    else $error("tick walked a dead slot");

  a_clear_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ppu_pkg::ST_CLR |=> state_r == ppu_pkg::ST_CLR || state_r == ppu_pkg::ST_IDLE)
    else $error("clearing pass left early");

endmodule
`default_nettype wire
